// ===== sv/srss_pkg.sv =====
// shared types, codes and helper functions of the sequenced record slot store
package srss_pkg;

	// request kinds
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// name limits and excluded characters
	localparam logic [7:0] NAME_MIN    = 8'h21;
	localparam logic [7:0] NAME_MAX    = 8'h7E;
	localparam logic [7:0] NAME_COMMA  = 8'h2C;
	localparam logic [7:0] NAME_EQUALS = 8'h3D;

	// serial-number half range and sequence start value
	localparam logic [7:0] SEQ_HALF = 8'd128;
	localparam logic [7:0] SEQ_INIT = 8'd1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} srss_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last;
	} srss_stat_t;

	// printable name check
	function automatic logic name_ok(input logic [7:0] n);
		return (n >= NAME_MIN) && (n <= NAME_MAX) && (n != NAME_COMMA) && (n != NAME_EQUALS);
	endfunction

	// a is newer than b under modulo-256 serial arithmetic
	function automatic logic seq_newer(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = a - b;
		return (d != 8'd0) && (d < SEQ_HALF);
	endfunction

endpackage

// ===== sv/sequenced_record_slot_store.sv =====
// Sequenced record slot store. A request is taken at a rising edge with start high and busy
// low. busy then stays high while the controller walks the slot table one slot per clock. The
// result registers load at the edge that ends the finish state after the walk, and the result
// beat is taken at the edge after that. It stays on the result ports for exactly one cycle,
// marked by done. The receiver cannot stall, so sample the result when done is high. busy is
// low again in the done cycle, so the next request may be issued there. Each request passes
// through the accepting idle cycle, the slot walk and the finish state, so a new request is
// taken only once the last one is through.
module sequenced_record_slot_store #(
	parameter int SLOT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rec_name,
	input  logic [15:0] rec_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  out_seq,
	output logic [7:0]  out_name,
	output logic [15:0] out_value
);
	import srss_pkg::*;

	srss_cmd_t  cmd;
	srss_stat_t stat;

	// controller
	srss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	srss_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_type  (req_type),
		.rec_name  (rec_name),
		.rec_value (rec_value),
		.done      (done),
		.status    (status),
		.out_seq   (out_seq),
		.out_name  (out_name),
		.out_value (out_value)
	);

endmodule

// ===== sv/srss_ctrl.sv =====
// controller state machine: accept, walk the slots, finish
module srss_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  srss_pkg::srss_stat_t   stat,
	output srss_pkg::srss_cmd_t    cmd,
	output logic                   busy
);
	import srss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		busy       = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/srss_dp.sv =====
// datapath: request registers, slot table, slot walk and result registers
module srss_dp #(
	parameter int SLOT_COUNT = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srss_pkg::srss_cmd_t    cmd,
	output srss_pkg::srss_stat_t   stat,
	input  logic [1:0]             req_type,
	input  logic [7:0]             rec_name,
	input  logic [15:0]            rec_value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [7:0]             out_seq,
	output logic [7:0]             out_name,
	output logic [15:0]            out_value
);
	import srss_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	// slot table
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [7:0]            slot_seq_q   [SLOT_COUNT];
	logic [7:0]            slot_name_q  [SLOT_COUNT];
	logic [15:0]           slot_value_q [SLOT_COUNT];
	logic [7:0]            next_seq_q;

	// captured request
	logic [1:0]  type_q;
	logic [7:0]  name_q;
	logic [15:0] value_q;
	logic        req_ok_q;

	// walk state
	logic [IDX_W-1:0] idx_q;
	logic             empty_found_q;
	logic [IDX_W-1:0] empty_idx_q;
	logic [IDX_W-1:0] vic_idx_q;
	logic [7:0]       vic_seq_q;
	logic             hit_found_q;
	logic [7:0]       hit_seq_q;
	logic [15:0]      hit_value_q;

	// current slot as seen by the walk
	logic        cur_valid;
	logic [7:0]  cur_seq;
	logic [7:0]  cur_name;
	logic [15:0] cur_value;
	logic        cur_match;
	logic [IDX_W-1:0] wr_idx;

	assign cur_valid = slot_valid_q[idx_q];
	assign cur_seq   = slot_seq_q[idx_q];
	assign cur_name  = slot_name_q[idx_q];
	assign cur_value = slot_value_q[idx_q];
	assign cur_match = cur_valid && (cur_name == name_q);
	assign wr_idx    = empty_found_q ? empty_idx_q : vic_idx_q;
	assign stat.last = (idx_q == IDX_LAST);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= req_type;
			name_q  <= rec_name;
			value_q <= rec_value;
		end
	end

	// request check and walk flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ok_q      <= 1'b0;
			idx_q         <= '0;
			empty_found_q <= 1'b0;
			hit_found_q   <= 1'b0;
		end else if (cmd.load) begin
			req_ok_q      <= ((req_type == REQ_WRITE) || (req_type == REQ_READ))
				&& name_ok(rec_name);
			idx_q         <= '0;
			empty_found_q <= 1'b0;
			hit_found_q   <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (!cur_valid) begin
				empty_found_q <= 1'b1;
			end
			if (cur_match) begin
				hit_found_q <= 1'b1;
			end
		end
	end

	// walk payload: first empty, oldest victim, newest name match
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (!cur_valid && !empty_found_q) begin
				empty_idx_q <= idx_q;
			end
			if ((idx_q == '0) || seq_newer(vic_seq_q, cur_seq)) begin
				vic_idx_q <= idx_q;
				vic_seq_q <= cur_seq;
			end
			if (cur_match && (!hit_found_q || seq_newer(cur_seq, hit_seq_q))) begin
				hit_seq_q   <= cur_seq;
				hit_value_q <= cur_value;
			end
		end
	end

	// slot valid bits and running sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			next_seq_q   <= SEQ_INIT;
		end else if (cmd.finish && req_ok_q && (type_q == REQ_WRITE)) begin
			slot_valid_q[wr_idx] <= 1'b1;
			next_seq_q           <= next_seq_q + 8'd1;
		end
	end

	// slot data write
	always_ff @(posedge clk) begin
		if (cmd.finish && req_ok_q && (type_q == REQ_WRITE)) begin
			slot_seq_q[wr_idx]   <= next_seq_q;
			slot_name_q[wr_idx]  <= name_q;
			slot_value_q[wr_idx] <= value_q;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (!req_ok_q) begin
				status    <= ST_INVALID;
				out_seq   <= 8'd0;
				out_name  <= 8'd0;
				out_value <= 16'd0;
			end else if (type_q == REQ_WRITE) begin
				status    <= ST_OK;
				out_seq   <= next_seq_q;
				out_name  <= name_q;
				out_value <= value_q;
			end else if (hit_found_q) begin
				status    <= ST_OK;
				out_seq   <= hit_seq_q;
				out_name  <= name_q;
				out_value <= hit_value_q;
			end else begin
				status    <= ST_NOT_FOUND;
				out_seq   <= 8'd0;
				out_name  <= name_q;
				out_value <= 16'd0;
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the sequenced record slot store
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import srss_pkg::*;

	localparam int SLOTS = 4;
	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_TAIL = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOWN_MISMATCHES = 10;

	// request kinds the block must reject
	localparam logic [1:0] REQ_SPARE2 = 2'd2;
	localparam logic [1:0] REQ_SPARE3 = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  seq;
		logic [7:0]  name;
		logic [15:0] value;
	} reply_t;

	// mirror of the slot table plus the queue of replies still owed
	class slot_table_model;
		bit         used[SLOTS];
		bit [7:0]   seq_of[SLOTS];
		bit [7:0]   name_of[SLOTS];
		bit [15:0]  value_of[SLOTS];
		bit [7:0]   next_seq;
		reply_t     owed_replies[$];
		int         mismatches;
		int         n_written;
		int         n_hit;
		int         n_missed;
		int         n_rejected;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 1'b0;
			end
			next_seq = SEQ_INIT;
		endfunction

		function bit legal_name(bit [7:0] n);
			return n >= NAME_MIN && n <= NAME_MAX && n != NAME_COMMA && n != NAME_EQUALS;
		endfunction

		// modulo-256 serial comparison: a strictly newer than b
		function bit is_newer(bit [7:0] a, bit [7:0] b);
			bit [7:0] d;
			d = a - b;
			return d != 8'd0 && d < SEQ_HALF;
		endfunction

		// first empty slot, else the oldest, lower index on ties
		function int victim_slot();
			int pick;
			pick = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!used[i]) return i;
			end
			for (int i = 1; i < SLOTS; i++) begin
				if (is_newer(seq_of[pick], seq_of[i])) pick = i;
			end
			return pick;
		endfunction

		function void note_request(bit [1:0] kind, bit [7:0] name, bit [15:0] value);
			reply_t r;
			int s;
			bit hit;
			r = '{status: ST_INVALID, seq: 8'd0, name: 8'd0, value: 16'd0};
			if (kind == REQ_WRITE && legal_name(name)) begin
				s = victim_slot();
				used[s] = 1'b1;
				seq_of[s] = next_seq;
				name_of[s] = name;
				value_of[s] = value;
				r = '{status: ST_OK, seq: next_seq, name: name, value: value};
				next_seq = next_seq + 8'd1;
				n_written++;
			end else if (kind == REQ_READ && legal_name(name)) begin
				hit = 1'b0;
				s = 0;
				// first match by index, replaced only by a strictly newer one
				for (int i = 0; i < SLOTS; i++) begin
					if (used[i] && name_of[i] == name) begin
						if (!hit || is_newer(seq_of[i], seq_of[s])) begin
							s = i;
							hit = 1'b1;
						end
					end
				end
				if (hit) begin
					r = '{status: ST_OK, seq: seq_of[s], name: name_of[s], value: value_of[s]};
					n_hit++;
				end else begin
					r = '{status: ST_NOT_FOUND, seq: 8'd0, name: name, value: 16'd0};
					n_missed++;
				end
			end else begin
				n_rejected++;
			end
			owed_replies.push_back(r);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (owed_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("mismatch: unexpected reply status=%0d seq=%0d name=%h value=%h",
						got.status, got.seq, got.name, got.value);
				return;
			end
			want = owed_replies.pop_front();
			if (got.status !== want.status || got.seq !== want.seq ||
				got.name !== want.name || got.value !== want.value) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("mismatch at %0t: expected st=%0d seq=%0d name=%h val=%h, got st=%0d seq=%0d name=%h val=%h",
						$realtime, want.status, want.seq, want.name, want.value,
						got.status, got.seq, got.name, got.value);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = 2'd0;
	logic [7:0]  rec_name = 8'd0;
	logic [15:0] rec_value = 16'd0;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  out_seq;
	logic [7:0]  out_name;
	logic [15:0] out_value;

	slot_table_model store_model;
	int unsigned cycle_count = 0;
	bit [7:0] name_pool[6];

	sequenced_record_slot_store #(
		.SLOT_COUNT(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.rec_name(rec_name),
		.rec_value(rec_value),
		.done(done),
		.status(status),
		.out_seq(out_seq),
		.out_name(out_name),
		.out_value(out_value)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result beats cannot be held off, so check each one as it passes
	always @(posedge clk) begin
		if (arst_n && done)
			store_model.check_reply('{status: status, seq: out_seq, name: out_name,
				value: out_value});
	end

	// present one request beat and hold it until the block takes it
	task automatic send_request(bit [1:0] kind, bit [7:0] name, bit [15:0] value);
		@(negedge clk);
		start = 1'b1;
		req_type = kind;
		rec_name = name;
		rec_value = value;
		do @(posedge clk); while (busy);
		store_model.note_request(kind, name, value);
	endtask

	// drop start for a burst of cycles with junk on the request fields
	task automatic hold_off(int cycles);
		@(negedge clk);
		start = 1'b0;
		req_type = 2'($urandom);
		rec_name = 8'($urandom);
		rec_value = 16'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	function automatic bit [7:0] any_legal_name();
		bit [7:0] n;
		n = 8'($urandom_range(NAME_MIN, NAME_MAX));
		while (n == NAME_COMMA || n == NAME_EQUALS)
			n = 8'($urandom_range(NAME_MIN, NAME_MAX));
		return n;
	endfunction

	initial begin
		bit [1:0]  kind;
		bit [7:0]  name;
		bit [15:0] value;
		int        roll;

		store_model = new();
		foreach (name_pool[i]) name_pool[i] = any_legal_name();
		name_pool[0] = NAME_MIN;
		name_pool[1] = NAME_MAX;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, fill, newest-of-duplicates, replacement, bad names and kinds
		send_request(REQ_READ, 8'h41, 16'hFFFF);
		send_request(REQ_WRITE, NAME_MIN, 16'h0000);
		send_request(REQ_WRITE, NAME_MAX, 16'hFFFF);
		send_request(REQ_WRITE, 8'h41, 16'h1234);
		send_request(REQ_WRITE, 8'h41, 16'h5678);
		send_request(REQ_READ, 8'h41, 16'h0000);
		send_request(REQ_READ, NAME_MIN, 16'h0000);
		send_request(REQ_READ, NAME_MAX, 16'h0000);
		send_request(REQ_WRITE, 8'h42, 16'hA5A5);
		send_request(REQ_READ, NAME_MIN, 16'h0000);
		send_request(REQ_READ, 8'h42, 16'h0000);
		send_request(REQ_WRITE, 8'h41, 16'h5A5A);
		send_request(REQ_READ, 8'h41, 16'h0000);
		send_request(REQ_WRITE, 8'h00, 16'hFFFF);
		send_request(REQ_WRITE, 8'h20, 16'h1111);
		send_request(REQ_WRITE, 8'h7F, 16'h2222);
		send_request(REQ_WRITE, 8'hFF, 16'h3333);
		send_request(REQ_WRITE, NAME_COMMA, 16'h4444);
		send_request(REQ_WRITE, NAME_EQUALS, 16'h5555);
		send_request(REQ_READ, NAME_COMMA, 16'h0000);
		send_request(REQ_READ, 8'h80, 16'h0000);
		send_request(REQ_SPARE2, 8'h41, 16'hFFFF);
		send_request(REQ_SPARE3, 8'h42, 16'hFFFF);
		send_request(REQ_READ, 8'h43, 16'h0000);

		// random: mostly legal traffic on a small name set, some noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 16));
			roll = $urandom_range(0, 9);
			value = 16'($urandom);
			if (roll < 8) begin
				kind = ($urandom_range(0, 9) < 7) ? REQ_WRITE : REQ_READ;
				name = ($urandom_range(0, 9) == 0) ? any_legal_name() :
					name_pool[$urandom_range(0, 5)];
			end else begin
				kind = 2'($urandom_range(0, 3));
				name = 8'($urandom_range(0, 255));
			end
			send_request(kind, name, value);
		end

		@(negedge clk);
		start = 1'b0;

		// drain, then allow for any stray beat
		while (store_model.owed_replies.size() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("covered %0d writes, %0d read hits, %0d read misses, %0d rejected requests",
			store_model.n_written, store_model.n_hit, store_model.n_missed,
			store_model.n_rejected);
		$display("sequence counter ended at %0d, %0d mismatches", store_model.next_seq,
			store_model.mismatches);
		if (store_model.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sequenced_record_slot_store.f =====
sv/srss_pkg.sv
sv/srss_ctrl.sv
sv/srss_dp.sv
sv/sequenced_record_slot_store.sv
tb/testbench.sv
